FILE: hdl/ncrp_pkg.sv
package ncrp_pkg;

  localparam logic [7:0] CH_ZERO  = 8'd48;
  localparam logic [7:0] CH_NINE  = 8'd57;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_DOT   = 8'd46;
  localparam logic [7:0] CH_NUL   = 8'd0;

  localparam int unsigned POS_W = 6;
  localparam logic [POS_W-1:0] MAX_CHARS = 6'd43;

  localparam logic [2:0] COMMAND_DIGITS = 3'd3;
  localparam logic [2:0] DIGIT_CNT_SAT  = 3'd7;

  localparam logic [9:0] CMD_SET_MOVE = 10'd1;

  localparam logic [1:0] TOK_COMMAND = 2'd0;
  localparam logic [1:0] TOK_PARAM   = 2'd1;
  localparam logic [1:0] TOK_LATER   = 2'd2;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       end_of_request;
  } req_item_t;

  typedef struct packed {
    logic        command_code;
    logic        param_present;
    logic [31:0] param_value;
  } rsp_item_t;

endpackage

FILE: hdl/ncrp_req_if.sv
interface ncrp_req_if;
  import ncrp_pkg::*;

  logic      valid;
  logic      ready;
  req_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

FILE: hdl/ncrp_rsp_if.sv
interface ncrp_rsp_if;
  import ncrp_pkg::*;

  logic      valid;
  logic      ready;
  rsp_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

FILE: hdl/numeric_command_request_parser.sv
// Parses a text request arriving one byte per item on req; the item flagged end_of_request
// produces one result on rsp by way of the input register and then the result register. A byte
// can be taken every cycle: each byte is held in an input register, and the parse state plus
// the result register update from it (digit checks and a times-ten accumulate on the
// 32-bit parameter). The only stall is when the registered byte closes a request while the
// previous result has not yet been taken on rsp. After each result the parser is back in its
// reset state, ready for the next request.
module numeric_command_request_parser (
  input logic        clk,
  input logic        rst,
  ncrp_req_if.sink   req,
  ncrp_rsp_if.source rsp
);
  import ncrp_pkg::*;

  // input register
  logic       s1_valid;
  logic [7:0] char_q;
  logic       last_q;

  // parse state
  logic [POS_W-1:0] byte_position, byte_position_next;
  logic             request_ended, request_ended_next;
  logic [1:0]       token_number, token_number_next;
  logic [9:0]       command_value, command_value_next;
  logic [2:0]       command_digit_count, command_digit_count_next;
  logic             format_error, format_error_next;
  logic             prev_was_separator, prev_was_separator_next;
  logic             dot_in_token, dot_in_token_next;
  logic [31:0]      param_accumulator, param_accumulator_next;
  logic             param_had_dot, param_had_dot_next;

  // result register
  logic      out_valid;
  rsp_item_t out_item, out_item_next;

  logic        advance;
  logic        take;
  logic        first;
  logic [3:0]  digit;
  logic [13:0] cmd_mul;
  logic [35:0] acc_mul;
  logic        req_ok;
  logic        code;
  logic        present;

  // a flagged byte needs a free result slot; other bytes never wait
  assign advance   = s1_valid && (!last_q || !out_valid || rsp.ready);
  assign req.ready = !s1_valid || advance;

  assign take  = !request_ended && (byte_position < MAX_CHARS);
  assign first = (byte_position == '0);
  assign digit = 4'(char_q - CH_ZERO);

  assign cmd_mul = 14'({command_value, 3'b000}) + 14'({command_value, 1'b0}) + 14'(digit);
  assign acc_mul = 36'({param_accumulator, 3'b000}) + 36'({param_accumulator, 1'b0})
                 + 36'(digit);

  always_comb begin
    byte_position_next       = byte_position;
    request_ended_next       = request_ended;
    token_number_next        = token_number;
    command_value_next       = command_value;
    command_digit_count_next = command_digit_count;
    format_error_next        = format_error;
    prev_was_separator_next  = prev_was_separator;
    dot_in_token_next        = dot_in_token;
    param_accumulator_next   = param_accumulator;
    param_had_dot_next       = param_had_dot;
    out_item_next            = out_item;
    req_ok                   = 1'b0;
    code                     = 1'b0;
    present                  = 1'b0;

    if (advance && take) begin
      if (char_q == CH_NUL) begin
        request_ended_next = 1'b1;
      end else begin
        byte_position_next = byte_position + 1'b1;
        if (char_q inside {[CH_ZERO:CH_NINE]}) begin
          prev_was_separator_next = 1'b0;
          if (token_number == TOK_COMMAND) begin
            if (command_digit_count < COMMAND_DIGITS) begin
              command_value_next = 10'(cmd_mul);
            end
            if (command_digit_count < DIGIT_CNT_SAT) begin
              command_digit_count_next = command_digit_count + 1'b1;
            end
          end else if (token_number == TOK_PARAM) begin
            // saturate at all ones on overflow
            param_accumulator_next = (acc_mul[35:32] != '0) ? '1 : acc_mul[31:0];
          end
        end else if (char_q == CH_SPACE) begin
          if (first || prev_was_separator) begin
            format_error_next = 1'b1;
          end
          prev_was_separator_next = 1'b1;
          dot_in_token_next       = 1'b0;
          if (token_number < TOK_LATER) begin
            token_number_next = token_number + 1'b1;
          end
        end else if (char_q == CH_DOT) begin
          if (first || prev_was_separator || dot_in_token || token_number == TOK_COMMAND) begin
            format_error_next = 1'b1;
          end
          prev_was_separator_next = 1'b1;
          dot_in_token_next       = 1'b1;
          if (token_number == TOK_PARAM) begin
            param_had_dot_next = 1'b1;
          end
        end else begin
          format_error_next = 1'b1;
        end
      end
    end

    if (advance && last_q) begin
      req_ok = (byte_position_next != '0) && !format_error_next && !prev_was_separator_next
            && (command_digit_count_next != '0)
            && (command_digit_count_next <= COMMAND_DIGITS);
      code    = req_ok && (command_value_next == CMD_SET_MOVE);
      present = code && (token_number_next != TOK_COMMAND);
      out_item_next.command_code  = code;
      out_item_next.param_present = present;
      out_item_next.param_value   = (present && !param_had_dot_next) ? param_accumulator_next
                                                                     : '0;
      // back to idle for the next request
      byte_position_next       = '0;
      request_ended_next       = 1'b0;
      token_number_next        = TOK_COMMAND;
      command_value_next       = '0;
      command_digit_count_next = '0;
      format_error_next        = 1'b0;
      prev_was_separator_next  = 1'b0;
      dot_in_token_next        = 1'b0;
      param_accumulator_next   = '0;
      param_had_dot_next       = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid            <= 1'b0;
      out_valid           <= 1'b0;
      byte_position       <= '0;
      request_ended       <= 1'b0;
      token_number        <= TOK_COMMAND;
      command_value       <= '0;
      command_digit_count <= '0;
      format_error        <= 1'b0;
      prev_was_separator  <= 1'b0;
      dot_in_token        <= 1'b0;
      param_accumulator   <= '0;
      param_had_dot       <= 1'b0;
    end else begin
      if (req.valid && req.ready) begin
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
      if (advance && last_q) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      byte_position       <= byte_position_next;
      request_ended       <= request_ended_next;
      token_number        <= token_number_next;
      command_value       <= command_value_next;
      command_digit_count <= command_digit_count_next;
      format_error        <= format_error_next;
      prev_was_separator  <= prev_was_separator_next;
      dot_in_token        <= dot_in_token_next;
      param_accumulator   <= param_accumulator_next;
      param_had_dot       <= param_had_dot_next;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      char_q <= req.payload.char_byte;
      last_q <= req.payload.end_of_request;
    end
    out_item <= out_item_next;
  end

  assign rsp.valid   = out_valid;
  assign rsp.payload = out_item;

  a_present_needs_code: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.payload.command_code |-> !rsp.payload.param_present)
    else $error("parameter flagged without a recognized command");

  a_value_zero_when_absent: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.payload.param_present |-> rsp.payload.param_value == '0)
    else $error("parameter value nonzero with no parameter");

  a_last_gives_result: assert property (@(posedge clk) disable iff (rst)
    advance && last_q |=> out_valid && byte_position == '0 && !request_ended)
    else $error("flagged byte did not produce a result and clear the state");

  a_position_bounded: assert property (@(posedge clk) disable iff (rst)
    byte_position <= MAX_CHARS)
    else $error("byte position ran past the character limit");

endmodule

FILE: test/numeric_command_request_parser_tb.sv
module numeric_command_request_parser_tb;
  import ncrp_pkg::*;

  localparam int QUIET_LIMIT = 5000;

  logic clk = 1'b0;
  logic rst;

  ncrp_req_if req_ch ();
  ncrp_rsp_if rsp_ch ();

  numeric_command_request_parser u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  always #5 clk = ~clk;

  // parser state as the predictor sees it
  typedef struct packed {
    logic [POS_W-1:0] pos;
    logic             ended;
    logic [1:0]       tok;
    logic [9:0]       cmd;
    logic [2:0]       ndig;
    logic             bad;
    logic             after_sep;
    logic             dot_seen;
    logic [31:0]      acc;
    logic             acc_dot;
  } parse_state_t;

  parse_state_t parse_state;
  rsp_item_t    pending_answers[$];
  logic [7:0]   req_bytes[$];

  int send_idle_pct;
  int stall_pct;
  int hold_off_req;
  int hold_left;
  int n_errors;
  int n_requests;
  int n_bytes;
  int n_answers;

  function automatic void absorb_char(input logic [7:0] ch);
    logic        at_start;
    logic [35:0] wide;
    if (ch == CH_NUL) begin
      parse_state.ended = 1'b1;
      return;
    end
    at_start = (parse_state.pos == 0);
    parse_state.pos = parse_state.pos + 1'b1;
    if (ch >= CH_ZERO && ch <= CH_NINE) begin
      parse_state.after_sep = 1'b0;
      if (parse_state.tok == TOK_COMMAND) begin
        if (parse_state.ndig < COMMAND_DIGITS)
          parse_state.cmd = parse_state.cmd * 10 + (ch - CH_ZERO);
        if (parse_state.ndig < DIGIT_CNT_SAT)
          parse_state.ndig = parse_state.ndig + 1'b1;
      end else if (parse_state.tok == TOK_PARAM) begin
        wide = parse_state.acc;
        wide = wide * 10 + (ch - CH_ZERO);
        parse_state.acc = (wide > 36'hFFFF_FFFF) ? 32'hFFFF_FFFF : wide[31:0];
      end
    end else if (ch == CH_SPACE) begin
      if (at_start || parse_state.after_sep)
        parse_state.bad = 1'b1;
      parse_state.after_sep = 1'b1;
      parse_state.dot_seen = 1'b0;
      if (parse_state.tok < TOK_LATER)
        parse_state.tok = parse_state.tok + 1'b1;
    end else if (ch == CH_DOT) begin
      if (at_start || parse_state.after_sep || parse_state.dot_seen ||
          parse_state.tok == TOK_COMMAND)
        parse_state.bad = 1'b1;
      parse_state.after_sep = 1'b1;
      parse_state.dot_seen = 1'b1;
      if (parse_state.tok == TOK_PARAM)
        parse_state.acc_dot = 1'b1;
    end else begin
      parse_state.bad = 1'b1;
    end
  endfunction

  // one accepted byte; a flagged byte closes the request and yields its answer
  function automatic void predict_byte(input logic [7:0] ch, input logic last);
    logic      ok;
    rsp_item_t ans;
    if (!parse_state.ended && parse_state.pos < MAX_CHARS)
      absorb_char(ch);
    if (!last)
      return;
    ok = parse_state.pos != 0 && !parse_state.bad && !parse_state.after_sep &&
         parse_state.ndig >= 1 && parse_state.ndig <= COMMAND_DIGITS;
    ans.command_code  = ok && parse_state.cmd == CMD_SET_MOVE;
    ans.param_present = ans.command_code && parse_state.tok >= TOK_PARAM;
    ans.param_value   = (ans.param_present && !parse_state.acc_dot) ? parse_state.acc : 32'd0;
    pending_answers.push_back(ans);
    parse_state = '0;
  endfunction

  task automatic send_byte(input logic [7:0] ch, input logic last);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid   <= 1'b1;
    req_ch.payload <= req_item_t'{char_byte: ch, end_of_request: last};
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    n_bytes++;
    predict_byte(ch, last);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++)
      send_byte(s[i], i == s.len() - 1);
    n_requests++;
  endtask

  task automatic send_request();
    foreach (req_bytes[i])
      send_byte(req_bytes[i], i == req_bytes.size() - 1);
    n_requests++;
  endtask

  task automatic wait_results();
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
  endtask

  function automatic void push_digits(input int unsigned n);
    repeat (n) req_bytes.push_back(CH_ZERO + 8'($urandom_range(9)));
  endfunction

  function automatic void push_param();
    if ($urandom_range(3) == 0) begin
      push_digits($urandom_range(1, 4));
      req_bytes.push_back(CH_DOT);
      push_digits($urandom_range(1, 4));
    end else begin
      // long runs push the parameter past 32 bits
      push_digits($urandom_range(1, ($urandom_range(4) == 0) ? 14 : 6));
    end
  endfunction

  function automatic logic [7:0] pick_separator();
    return $urandom_range(1) ? CH_SPACE : CH_DOT;
  endfunction

  function automatic void build_request();
    int kind;
    int n_par;
    kind = $urandom_range(99);
    req_bytes.delete();
    if (kind < 10) begin
      repeat ($urandom_range(1, 10)) req_bytes.push_back(8'($urandom_range(255)));
      return;
    end
    case ($urandom_range(5))
      0, 1: req_bytes.push_back("1");
      2: begin
        req_bytes.push_back("0");
        req_bytes.push_back("1");
      end
      3: begin
        req_bytes.push_back("0");
        req_bytes.push_back("0");
        req_bytes.push_back("1");
      end
      default: push_digits($urandom_range(1, 4));
    endcase
    // long requests can run past the byte limit
    n_par = (kind >= 90) ? 12 : $urandom_range(0, 3);
    repeat (n_par) begin
      req_bytes.push_back(CH_SPACE);
      push_param();
    end
    if (kind >= 70 && kind < 90) begin
      case ($urandom_range(5))
        0: req_bytes.insert($urandom_range(req_bytes.size()), 8'($urandom_range(255)));
        1: req_bytes.insert($urandom_range(req_bytes.size()), CH_SPACE);
        2: req_bytes.push_back(pick_separator());
        3: req_bytes.push_front(pick_separator());
        4: begin
          req_bytes.insert($urandom_range(req_bytes.size()), CH_NUL);
          repeat ($urandom_range(0, 4)) req_bytes.push_back(8'($urandom_range(255)));
        end
        default: req_bytes.insert($urandom_range(req_bytes.size()), CH_DOT);
      endcase
    end
  endfunction

  task automatic set_idling(input int sender_pct, input int receiver_pct);
    send_idle_pct = sender_pct;
    stall_pct     = receiver_pct;
  endtask

  task automatic test_directed();
    set_idling(0, 0);
    send_text("1");
    send_text("1 42");
    send_text("001 7.5");
    send_text("2 5");
    send_text(" 1");
    send_text("0011");
    send_text("1 ");
    send_text("1.5");
    send_byte("1", 1'b0);
    send_byte(8'hFF, 1'b1);
    n_requests++;
    send_byte(CH_NUL, 1'b1);
    n_requests++;
    wait_results();
  endtask

  task automatic test_random(input int n_items, input int sender_pct, input int receiver_pct);
    int start;
    set_idling(sender_pct, receiver_pct);
    start = n_bytes;
    while (n_bytes - start < n_items) begin
      build_request();
      send_request();
    end
    wait_results();
  endtask

  // output side held off long enough that the parser has to stall its input
  task automatic test_output_hold();
    set_idling(0, 0);
    hold_off_req = 400;
    repeat (30) send_text("1 5");
    wait_results();
  endtask

  always @(negedge clk) begin
    if (hold_off_req != 0) begin
      hold_left    = hold_off_req;
      hold_off_req = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    rsp_item_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_answers.size() == 0) begin
        n_errors++;
        $display("%0t: unexpected answer %p", $time, rsp_ch.payload);
      end else begin
        want = pending_answers.pop_front();
        n_answers++;
        if (rsp_ch.payload.command_code !== want.command_code) begin
          n_errors++;
          $display("%0t: command_code expected %0d got %0d", $time,
                   want.command_code, rsp_ch.payload.command_code);
        end
        if (rsp_ch.payload.param_present !== want.param_present) begin
          n_errors++;
          $display("%0t: param_present expected %0d got %0d", $time,
                   want.param_present, rsp_ch.payload.param_present);
        end
        if (rsp_ch.payload.param_value !== want.param_value) begin
          n_errors++;
          $display("%0t: param_value expected %0d got %0d", $time,
                   want.param_value, rsp_ch.payload.param_value);
        end
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("timeout: nothing moved for %0d cycles", QUIET_LIMIT);
    $display("numeric_command_request_parser_tb: errors");
    $finish;
  end

  initial begin
    rst            = 1'b1;
    req_ch.valid   = 1'b0;
    req_ch.payload = '0;
    parse_state    = '0;
    send_idle_pct  = 0;
    stall_pct      = 0;
    hold_off_req   = 0;
    hold_left      = 0;
    n_errors       = 0;
    n_requests     = 0;
    n_bytes        = 0;
    n_answers      = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_random(500, 0, 0);
    test_random(450, 87, 0);
    test_output_hold();
    test_random(450, 0, 87);
    test_random(450, 16, 16);

    repeat (8) @(posedge clk);
    if (pending_answers.size() != 0) begin
      n_errors++;
      $display("%0t: %0d answers never arrived", $time, pending_answers.size());
    end
    $display("covered %0d requests in %0d bytes, %0d answers checked", n_requests, n_bytes,
             n_answers);
    $display("with free flow, sparse sender, stalled receiver, mixed gaps and a long hold-off");
    if (n_errors == 0)
      $display("numeric_command_request_parser_tb: clean");
    else
      $display("numeric_command_request_parser_tb: errors");
    $finish;
  end

endmodule
